[src/srvramp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package srvramp_pkg;

  localparam int CHANNELS_DEF = 18;

  // Field widths fixed by the interface.
  localparam int KIND_W  = 2;
  localparam int CHAN_W  = 5;
  localparam int ANGLE_W = 8;
  localparam int PULSE_W = 12;
  localparam int CUR_W   = 10;
  localparam int STEP_W  = 8;
  localparam int MOVES_W = 10;

  // Divider operands: distance reaches 255 - (-512), divisor is steps_per_move (1 when it is 0).
  localparam int DIST_W = 10;
  localparam int DIVR_W = 8;

  // Configuration port.
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [7:0]  STEPS_RST = 8'd10;
  localparam logic [9:0]  TICKS_RST = 10'd50;
  localparam logic [11:0] PMIN_RST  = 12'd150;
  localparam logic [11:0] PMAX_RST  = 12'd600;

  // Pulse map: |cur * span| / 180 is done as (|p| >> 2) / 45, and the
  // division by 45 as a multiply by a rounded-up reciprocal. The error term
  // of the reciprocal times the largest 19-bit operand stays below 2^25.
  localparam int PROD_W      = 23;
  localparam int MAG_W       = 19;
  localparam int RECIP_SHIFT = 25;
  localparam int RECIP_W     = 20;
  localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'((2 ** RECIP_SHIFT + 44) / 45);
  localparam int QUO_W       = 14;
  localparam int QPROD_W     = MAG_W + RECIP_W;

  localparam int FIFO_DEPTH = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_TARGET  = 2'd0,
    KIND_CURRENT = 2'd1,
    KIND_TICK    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_STEPS = 2'd0,
    REG_TICKS = 2'd1,
    REG_PMIN  = 2'd2,
    REG_PMAX  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_TGT,
    ST_RD_CUR,
    ST_DIV,
    ST_TICK,
    ST_TDONE
  } srv_state_t;

  typedef struct packed {
    logic [CUR_W-1:0]   cur;
    logic [ANGLE_W-1:0] tgt;
    logic [STEP_W-1:0]  stp;
  } chan_ent_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic [PULSE_W-1:0] pulse;
    logic               last;
  } out_beat_t;

endpackage

`default_nettype wire

[src/srvramp_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module srvramp_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [srvramp_pkg::DIST_W-1:0] dividend,
  input  logic [srvramp_pkg::DIVR_W-1:0] divisor,
  output logic                          done,
  output logic [srvramp_pkg::DIST_W-1:0] quotient
);
  import srvramp_pkg::*;

  localparam int CNT_W = $clog2(DIST_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIVR_W-1:0] rem_r;
  logic [DIST_W-1:0] quo_r;
  logic [DIVR_W-1:0] dvs_r;

  logic [DIVR_W:0]   trial;
  logic [DIVR_W+1:0] diff;
  logic              fits;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    trial = {rem_r, quo_r[DIST_W-1]};
    diff  = {1'b0, trial} - {2'b00, dvs_r};
    fits  = ~diff[DIVR_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIST_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
      quo_r <= {quo_r[DIST_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

[src/servo_ramp_interpolator_unit.sv]
// Target beat: state read, divide and write-back, all done before the next beat is taken.
// Set-current beat: state read, then write-back. Kind 3 and out-of-range channels: no effect.
// Tick beat: one channel read-modify-write per cycle while the FIFO credit allows it;
// pulses then leave one per cycle while the output is not stalled, paced by an 8-beat FIFO.
// Reset (synchronous, active low) restores the registers and clears per-channel valid bits,
// so every channel reads as zero; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module servo_ramp_interpolator_unit #(
  parameter int CHANNELS = srvramp_pkg::CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [srvramp_pkg::KIND_W-1:0]  in_kind,
  input  logic [srvramp_pkg::CHAN_W-1:0]  in_channel,
  input  logic [srvramp_pkg::ANGLE_W-1:0] in_angle,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [srvramp_pkg::CHAN_W-1:0]  out_channel,
  output logic [srvramp_pkg::PULSE_W-1:0] out_pulse,
  output logic                            out_last,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [srvramp_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [srvramp_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [srvramp_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import srvramp_pkg::*;

  localparam int CH_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int OCC_W   = FIFO_AW + 2;
  localparam logic [CH_AW-1:0] CH_LAST = CH_AW'(CHANNELS - 1);

  // ---------------- configuration registers ----------------
  logic [7:0]  spm_r;
  logic [9:0]  tpm_r;
  logic [11:0] pmin_r;
  logic [11:0] pmax_r;
  logic        cfg_wr;
  cfg_reg_t    cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spm_r  <= STEPS_RST;
      tpm_r  <= TICKS_RST;
      pmin_r <= PMIN_RST;
      pmax_r <= PMAX_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_STEPS: spm_r  <= cfg_pwdata[7:0];
        REG_TICKS: tpm_r  <= cfg_pwdata[9:0];
        REG_PMIN:  pmin_r <= cfg_pwdata[11:0];
        REG_PMAX:  pmax_r <= cfg_pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_STEPS: cfg_prdata = {24'd0, spm_r};
      REG_TICKS: cfg_prdata = {22'd0, tpm_r};
      REG_PMIN:  cfg_prdata = {20'd0, pmin_r};
      REG_PMAX:  cfg_prdata = {20'd0, pmax_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // ---------------- declarations ----------------
  srv_state_t state_r, state_nxt;

  logic               in_acc;
  kind_t              kind;
  logic               ch_ok;
  logic [ANGLE_W-1:0] hold_ang_r;
  logic [CUR_W-1:0]   hold_cur_r;
  logic [CH_AW-1:0]   rd_addr_hold;
  logic [MOVES_W-1:0] moves_left_r;
  logic               moving_r;
  logic [CH_AW-1:0]   ch_cnt_r;

  logic               rd_en;
  logic [CH_AW-1:0]   rd_addr;
  logic               mem_we;
  logic [CH_AW-1:0]   mem_waddr;
  chan_ent_t          mem_wdata;
  chan_ent_t          mem [CHANNELS];
  chan_ent_t          mem_q_r;
  logic [CHANNELS-1:0] ent_vld_r;
  logic               rd_vld_r;
  chan_ent_t          ent_q;

  logic               div_start;
  logic               div_done;
  logic [DIST_W-1:0]  dist_mag;
  logic [DIVR_W-1:0]  divr;
  logic [DIST_W-1:0]  div_q;
  logic [STEP_W-1:0]  step_sat;

  logic               issue;
  logic               credit_ok;
  logic [OCC_W-1:0]   occ;

  logic               s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic [CH_AW-1:0]   s1_ch_r, s2_ch_r, s3_ch_r, s4_ch_r, s5_ch_r;
  logic [CUR_W-1:0]   s1_cur_new;
  logic [CUR_W-1:0]   s2_cur_r;
  logic signed [12:0] span;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] s3_prod_r;
  logic [PROD_W-1:0]  mag;
  logic [MAG_W-1:0]   s4_mag_r;
  logic               s4_neg_r;
  logic [QPROD_W-1:0] qprod;
  logic [QUO_W-1:0]   s5_q_r;
  logic               s5_neg_r;
  logic [15:0]        qs;
  logic [15:0]        pv;
  out_beat_t          push_beat;

  out_beat_t          fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   fifo_cnt_r;
  logic               push, pop;

  // ---------------- input decode ----------------
  assign kind   = kind_t'(in_kind);
  assign ch_ok  = ({1'b0, in_channel} < (CHAN_W + 1)'(CHANNELS));
  assign in_acc = in_valid & ~in_stall;

  // ---------------- control FSM ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (kind)
            KIND_TARGET:  state_nxt = ch_ok ? ST_RD_TGT : ST_IDLE;
            KIND_CURRENT: state_nxt = ch_ok ? ST_RD_CUR : ST_IDLE;
            KIND_TICK:    state_nxt = ST_TICK;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RD_TGT: state_nxt = ST_DIV;
      ST_RD_CUR: state_nxt = ST_IDLE;
      ST_DIV:    state_nxt = div_done ? ST_IDLE : ST_DIV;
      ST_TICK:   state_nxt = (issue && ch_cnt_r == CH_LAST) ? ST_TDONE : ST_TICK;
      ST_TDONE:  state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    rd_en     = 1'b0;
    rd_addr   = ch_cnt_r;
    div_start = 1'b0;
    issue     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = s1_ch_r;
    mem_wdata = '{cur: s1_cur_new, tgt: ent_q.tgt, stp: ent_q.stp};
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        rd_en    = in_valid && ch_ok && (kind == KIND_TARGET || kind == KIND_CURRENT);
        rd_addr  = in_channel[CH_AW-1:0];
      end
      ST_RD_TGT: begin
        div_start = 1'b1;
      end
      ST_RD_CUR: begin
        mem_we    = 1'b1;
        mem_waddr = rd_addr_hold;
        mem_wdata = '{cur: CUR_W'(hold_ang_r), tgt: ent_q.tgt, stp: ent_q.stp};
      end
      ST_DIV: begin
        mem_we    = div_done;
        mem_waddr = rd_addr_hold;
        mem_wdata = '{cur: hold_cur_r, tgt: hold_ang_r, stp: step_sat};
      end
      ST_TICK: begin
        issue  = credit_ok;
        rd_en  = credit_ok;
        mem_we = s1_v_r & moving_r;
      end
      ST_TDONE: begin
        mem_we = s1_v_r & moving_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      moves_left_r <= '0;
      moving_r     <= 1'b0;
      ch_cnt_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && kind == KIND_TICK) begin
        moving_r <= (moves_left_r != '0);
        ch_cnt_r <= '0;
        if (moves_left_r != '0) begin
          moves_left_r <= moves_left_r - MOVES_W'(1);
        end
      end else if (state_r == ST_DIV && div_done) begin
        moves_left_r <= tpm_r;
      end
      if (issue) begin
        ch_cnt_r <= ch_cnt_r + CH_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hold_ang_r   <= in_angle;
      rd_addr_hold <= in_channel[CH_AW-1:0];
    end
    if (state_r == ST_RD_TGT) begin
      hold_cur_r <= ent_q.cur;
    end
  end

  // ---------------- channel state memory ----------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (mem_we) begin
        ent_vld_r[mem_waddr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= ent_vld_r[rd_addr];
      end
    end
  end

  // A channel that was never written reads as its reset value of zero.
  assign ent_q = rd_vld_r ? mem_q_r : '0;

  // ---------------- step size divider ----------------
  logic signed [CUR_W:0] dist_s;

  always_comb begin
    dist_s   = $signed({3'b000, hold_ang_r}) - $signed({ent_q.cur[CUR_W-1], ent_q.cur});
    dist_mag = dist_s[CUR_W] ? DIST_W'(-dist_s) : dist_s[DIST_W-1:0];
    divr     = (spm_r == '0) ? DIVR_W'(1) : spm_r;
  end

  srvramp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dist_mag),
    .divisor  (divr),
    .done     (div_done),
    .quotient (div_q)
  );

  assign step_sat = (div_q[DIST_W-1:STEP_W] != '0) ? '1 : div_q[STEP_W-1:0];

  // ---------------- tick pipeline ----------------
  // Stage 1 sees the memory word of the channel issued in the previous cycle.
  always_comb begin
    s1_cur_new = ent_q.cur;
    if (moving_r) begin
      if ($signed({3'b000, ent_q.tgt}) < $signed({ent_q.cur[CUR_W-1], ent_q.cur})) begin
        s1_cur_new = ent_q.cur - {2'b00, ent_q.stp};
      end else if ($signed({3'b000, ent_q.tgt}) > $signed({ent_q.cur[CUR_W-1], ent_q.cur}))
      begin
        s1_cur_new = ent_q.cur + {2'b00, ent_q.stp};
      end
    end
  end

  always_comb begin
    span  = $signed({1'b0, pmax_r}) - $signed({1'b0, pmin_r});
    prod  = $signed(s2_cur_r) * span;
    mag   = s3_prod_r[PROD_W-1] ? (PROD_W'(0) - s3_prod_r) : s3_prod_r;
    qprod = QPROD_W'(s4_mag_r) * QPROD_W'(RECIP_K);
    qs    = s5_neg_r ? (16'd0 - {2'b00, s5_q_r}) : {2'b00, s5_q_r};
    pv    = qs + {4'b0000, pmin_r};
    push_beat.chan = CHAN_W'(s5_ch_r);
    push_beat.last = (s5_ch_r == CH_LAST);
    if (pv[15]) begin
      push_beat.pulse = '0;
    end else if (pv[14:PULSE_W] != '0) begin
      push_beat.pulse = '1;
    end else begin
      push_beat.pulse = pv[PULSE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_ch_r   <= ch_cnt_r;
    s2_ch_r   <= s1_ch_r;
    s2_cur_r  <= s1_cur_new;
    s3_ch_r   <= s2_ch_r;
    s3_prod_r <= prod;
    s4_ch_r   <= s3_ch_r;
    s4_mag_r  <= mag[MAG_W+1:2];
    s4_neg_r  <= s3_prod_r[PROD_W-1];
    s5_ch_r   <= s4_ch_r;
    s5_q_r    <= qprod[RECIP_SHIFT +: QUO_W];
    s5_neg_r  <= s4_neg_r;
  end

  // ---------------- output FIFO ----------------
  // A channel is issued only when the FIFO has room for it and for
  // every beat already in the pipeline, so the pipeline never stalls.
  assign occ = OCC_W'(fifo_cnt_r) + OCC_W'(s1_v_r) + OCC_W'(s2_v_r) + OCC_W'(s3_v_r)
             + OCC_W'(s4_v_r) + OCC_W'(s5_v_r);
  assign credit_ok = (occ < OCC_W'(FIFO_DEPTH));

  assign push = s5_v_r;
  assign pop  = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      if (push && !pop) begin
        fifo_cnt_r <= fifo_cnt_r + (FIFO_AW + 1)'(1);
      end else if (pop && !push) begin
        fifo_cnt_r <= fifo_cnt_r - (FIFO_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= push_beat;
    end
  end

  assign out_valid   = (fifo_cnt_r != '0);
  assign out_channel = fifo_r[rd_ptr_r].chan;
  assign out_pulse   = fifo_r[rd_ptr_r].pulse;
  assign out_last    = fifo_r[rd_ptr_r].last;

`ifndef SYNTHESIS
  a_fifo_credit: assert property (@(posedge clk) disable iff (!rst_n)
    occ <= OCC_W'(FIFO_DEPTH))
    else $error("output FIFO credit exceeded");

  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

  a_tick_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (state_r == ST_TICK || state_r == ST_TDONE))
    else $error("channel write-back outside a tick");

  a_tick_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TDONE) |-> (s1_v_r && s1_ch_r == CH_LAST))
    else $error("tick ended before the last channel was written");
`endif

endmodule

`default_nettype wire

[verif/servo_ramp_pulse_checker.sv]
`timescale 1ns / 1ps

module servo_ramp_pulse_checker #(
  parameter int CHANNELS = srvramp_pkg::CHANNELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [srvramp_pkg::KIND_W-1:0]   in_kind,
  input  logic [srvramp_pkg::CHAN_W-1:0]   in_channel,
  input  logic [srvramp_pkg::ANGLE_W-1:0]  in_angle,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [srvramp_pkg::CHAN_W-1:0]   out_channel,
  input  logic [srvramp_pkg::PULSE_W-1:0]  out_pulse,
  input  logic                             out_last,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [srvramp_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [srvramp_pkg::CFG_DW-1:0]   cfg_pwdata,
  input  logic                             cfg_pready,
  output int                               mismatches,
  output int                               pulses_pending,
  output int                               pulses_checked,
  output int                               ticks_seen
);
  import srvramp_pkg::*;

  // Shadow copy of the servo state and the register file.
  logic signed [CUR_W-1:0] cur_ang  [CHANNELS];
  logic [ANGLE_W-1:0]      tgt_ang  [CHANNELS];
  logic [STEP_W-1:0]       step_amt [CHANNELS];
  logic [MOVES_W-1:0]      moves_left;
  logic [7:0]              steps_per_move;
  logic [9:0]              ticks_per_move;
  logic [PULSE_W-1:0]      pulse_min;
  logic [PULSE_W-1:0]      pulse_max;

  out_beat_t pulse_due_q[$];

  function automatic logic [PULSE_W-1:0] angle_to_count(logic signed [CUR_W-1:0] ang);
    longint span;
    longint val;
    span = longint'(pulse_max) - longint'(pulse_min);
    // SystemVerilog signed division truncates toward zero, as the block does.
    val = (longint'(ang) * span) / 180 + longint'(pulse_min);
    if (val < 0) return '0;
    if (val > 4095) return '1;
    return PULSE_W'(val);
  endfunction

  task automatic flag(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%m: %s", msg);
    end
  endtask

  task automatic apply_servo_beat();
    int ang_gap;
    int divisor;
    int quot;
    int next_ang;
    out_beat_t beat;
    case (kind_t'(in_kind))
      KIND_TARGET: begin
        if (in_channel < CHANNELS) begin
          tgt_ang[in_channel] = in_angle;
          ang_gap = int'(in_angle) - int'(cur_ang[in_channel]);
          if (ang_gap < 0) ang_gap = -ang_gap;
          divisor = (steps_per_move == 0) ? 1 : int'(steps_per_move);
          quot = ang_gap / divisor;
          step_amt[in_channel] = (quot > 255) ? 8'd255 : quot[7:0];
          moves_left = ticks_per_move;
        end
      end
      KIND_CURRENT: begin
        if (in_channel < CHANNELS) cur_ang[in_channel] = {2'b00, in_angle};
      end
      KIND_TICK: begin
        ticks_seen++;
        if (moves_left != 0) begin
          moves_left = moves_left - 1'b1;
          // No clamp at the target: a large step overshoots and swings back.
          for (int i = 0; i < CHANNELS; i++) begin
            next_ang = int'(cur_ang[i]);
            if (int'(tgt_ang[i]) < next_ang) next_ang -= int'(step_amt[i]);
            else if (int'(tgt_ang[i]) > next_ang) next_ang += int'(step_amt[i]);
            cur_ang[i] = next_ang[CUR_W-1:0];
          end
        end
        for (int i = 0; i < CHANNELS; i++) begin
          beat.chan  = CHAN_W'(i);
          beat.pulse = angle_to_count(cur_ang[i]);
          beat.last  = (i == CHANNELS - 1);
          pulse_due_q.push_back(beat);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_pulse_beat();
    out_beat_t want;
    if (pulse_due_q.size() == 0) begin
      flag($sformatf("unexpected pulse beat: chan %0d pulse %0d last %0d",
                     out_channel, out_pulse, out_last));
    end else begin
      want = pulse_due_q.pop_front();
      pulses_checked++;
      if (out_channel !== want.chan || out_pulse !== want.pulse || out_last !== want.last) begin
        flag($sformatf("pulse beat: expected chan %0d pulse %0d last %0d, got chan %0d pulse %0d last %0d",
                       want.chan, want.pulse, want.last, out_channel, out_pulse, out_last));
      end
    end
  endtask

  initial begin
    mismatches     = 0;
    pulses_pending = 0;
    pulses_checked = 0;
    ticks_seen     = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cur_ang[i]  = '0;
        tgt_ang[i]  = '0;
        step_amt[i] = '0;
      end
      moves_left     = '0;
      steps_per_move = STEPS_RST;
      ticks_per_move = TICKS_RST;
      pulse_min      = PMIN_RST;
      pulse_max      = PMAX_RST;
      pulse_due_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_reg_t'(cfg_paddr[3:2]))
          REG_STEPS: steps_per_move = cfg_pwdata[7:0];
          REG_TICKS: ticks_per_move = cfg_pwdata[9:0];
          REG_PMIN:  pulse_min      = cfg_pwdata[11:0];
          REG_PMAX:  pulse_max      = cfg_pwdata[11:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) apply_servo_beat();
      if (out_valid && !out_stall) check_pulse_beat();
    end
    pulses_pending = pulse_due_q.size();
  end

endmodule

[verif/servo_ramp_interpolator_unit_tb.sv]
`timescale 1ns / 1ps

module servo_ramp_interpolator_unit_tb;
  import srvramp_pkg::*;

  localparam int CHANNELS      = CHANNELS_DEF;
  localparam int SETTLE_CYCLES = 30;
  localparam int CYCLE_LIMIT   = 1000000;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [KIND_W-1:0]  in_kind = KIND_NONE;
  logic [CHAN_W-1:0]  in_channel = '0;
  logic [ANGLE_W-1:0] in_angle = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CHAN_W-1:0]  out_channel;
  logic [PULSE_W-1:0] out_pulse;
  logic               out_last;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]  cfg_paddr = '0;
  logic [CFG_DW-1:0]  cfg_pwdata = '0;
  logic [CFG_DW-1:0]  cfg_prdata;
  logic               cfg_pready;

  int mismatches;
  int pulses_pending;
  int pulses_checked;
  int ticks_seen;
  int beats_sent = 0;
  int settings_used = 0;
  int cycle_count = 0;
  bit idle_on = 1'b1;

  servo_ramp_interpolator_unit #(.CHANNELS(CHANNELS)) dut (.*);

  servo_ramp_pulse_checker #(.CHANNELS(CHANNELS)) u_checker (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_kind, .in_channel, .in_angle,
    .out_valid, .out_stall, .out_channel, .out_pulse, .out_last,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .mismatches, .pulses_pending, .pulses_checked, .ticks_seen
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: random stall bursts while idling is enabled.
  initial begin
    forever begin
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (idle_on) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("servo_ramp_interpolator_unit_tb: done, errors");
    $finish;
  end

  task automatic send_beat(kind_t kind, logic [CHAN_W-1:0] chan, logic [ANGLE_W-1:0] ang);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_channel <= chan;
    in_angle   <= ang;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic cfg_write(cfg_reg_t idx, int unsigned value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Drop valid, drain every expected pulse, then give a pending divide time to finish.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pulses_pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [ANGLE_W-1:0] pick_angle();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd180;
    if (r <= 3) return ANGLE_W'($urandom_range(181, 255));
    return ANGLE_W'($urandom_range(0, 180));
  endfunction

  task automatic run_phase(int unsigned steps, int unsigned ticks, int unsigned pmin,
                           int unsigned pmax, int n_beats, bit with_idle);
    int counted;
    int r;
    drain();
    cfg_write(REG_STEPS, steps);
    cfg_write(REG_TICKS, ticks);
    cfg_write(REG_PMIN, pmin);
    cfg_write(REG_PMAX, pmax);
    settings_used++;
    idle_on = with_idle;
    counted = 0;
    while (counted < n_beats) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        send_beat(KIND_TARGET, CHAN_W'($urandom_range(0, CHANNELS - 1)), pick_angle());
        counted++;
      end else if (r < 50) begin
        send_beat(KIND_CURRENT, CHAN_W'($urandom_range(0, CHANNELS - 1)), pick_angle());
        counted++;
      end else if (r < 90) begin
        // Channel and angle are don't-care on a tick; random values exercise the bits.
        send_beat(KIND_TICK, CHAN_W'($urandom), ANGLE_W'($urandom));
        counted++;
      end else if (r < 94) begin
        send_beat(KIND_NONE, CHAN_W'($urandom), ANGLE_W'($urandom));
      end else begin
        send_beat(($urandom_range(0, 1) != 0) ? KIND_TARGET : KIND_CURRENT,
                  CHAN_W'($urandom_range(CHANNELS, 31)), ANGLE_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: idle ticks, ignored beats, large jumps and overshoot.
    settings_used++;
    send_beat(KIND_TICK, 5'd0, 8'd0);
    send_beat(KIND_NONE, 5'd31, 8'd255);
    send_beat(KIND_TARGET, 5'd18, 8'd90);
    send_beat(KIND_CURRENT, 5'd31, 8'd255);
    send_beat(KIND_TICK, 5'd31, 8'd255);
    send_beat(KIND_CURRENT, 5'd0, 8'd180);
    send_beat(KIND_CURRENT, 5'd17, 8'd255);
    send_beat(KIND_TARGET, 5'd0, 8'd0);
    send_beat(KIND_TARGET, 5'd17, 8'd0);
    send_beat(KIND_TARGET, 5'd5, 8'd180);
    send_beat(KIND_CURRENT, 5'd3, 8'd95);
    send_beat(KIND_TARGET, 5'd3, 8'd100);
    send_beat(KIND_TARGET, 5'd4, 8'd255);
    send_beat(KIND_CURRENT, 5'd4, 8'd250);
    send_beat(KIND_TICK, 5'd0, 8'd0);
    send_beat(KIND_TICK, 5'd0, 8'd0);
    send_beat(KIND_TICK, 5'd0, 8'd0);
    send_beat(KIND_CURRENT, 5'd5, 8'd175);
    send_beat(KIND_TICK, 5'd0, 8'd0);
    send_beat(KIND_TICK, 5'd0, 8'd0);

    run_phase(1, 1023, 0, 4095, 70, 1'b1);
    run_phase(255, 1, 4095, 0, 70, 1'b1);
    run_phase(0, 0, 2048, 2047, 70, 1'b1);
    run_phase($urandom_range(0, 255), $urandom_range(0, 60),
              $urandom_range(0, 4095), $urandom_range(0, 4095), 70, 1'b1);
    run_phase(4, 30, 150, 600, 70, 1'b0);

    drain();
    $display("Sent %0d input beats under %0d register settings; %0d ticks gave %0d checked pulse beats.",
             beats_sent, settings_used, ticks_seen, pulses_checked);
    if (mismatches == 0) begin
      $display("servo_ramp_interpolator_unit_tb: done, clean");
    end else begin
      $display("servo_ramp_interpolator_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
